/* hdl/multi_queue_keyed_message_tracker_core_defines.svh */
// assertion macros for the message tracker core
// no dependencies; simulation only bodies, empty under synthesis
`ifndef MULTI_QUEUE_KEYED_MESSAGE_TRACKER_CORE_DEFINES_SVH
`define MULTI_QUEUE_KEYED_MESSAGE_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MQT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MQT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MQT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MQT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/mqt_pkg.sv */
// types and codes for the message tracker core
// no dependencies
package mqt_pkg;
  localparam logic [2:0] CMD_ENQ    = 3'd0;
  localparam logic [2:0] CMD_REMID  = 3'd1;
  localparam logic [2:0] CMD_REMFST = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_CLEAN  = 3'd4;
  localparam logic [2:0] CMD_MOVE   = 3'd5;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;
  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  queue_sel;
    logic [1:0]  dest_queue;
    logic [31:0] msg_id;
    logic [15:0] owner_tag;
  } req_t;
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic [31:0] found_msg_id;
    logic [15:0] found_owner;
    logic [6:0]  removed_count;
    logic [6:0]  queue_length;
  } rsp_t;
endpackage

/* hdl/mqt_ram.sv */
// generic single port write, single port read ram with registered read
// no dependencies
module mqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/multi_queue_keyed_message_tracker_core.sv */
// channel  dir  payload         handshake
// req      in   mqt_pkg::req_t  req_valid / req_stall
// rsp      out  mqt_pkg::rsp_t  rsp_valid / rsp_stall
// one item at a time; enqueue takes a free slot and appends it, a keyed search walks
// the queue slot by slot, unlink patches the predecessor link, move ends in an append;
// clean_owner unlinks each slot of the owner that it walks past;
// all of these steps go through the one read port of the slot memory.
// after reset a link pass writes the free chain over all ENTRIES slots, no items taken.
// a stalled result holds the engine in its output step; input waits for idle.
// depends on mqt_pkg, mqt_ram and the defines header
`include "multi_queue_keyed_message_tracker_core_defines.svh"
module multi_queue_keyed_message_tracker_core #(
  parameter int ENTRIES = 64,
  parameter int QUEUES  = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mqt_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mqt_pkg::rsp_t  rsp
);
  import mqt_pkg::*;
  localparam int AW = $clog2(ENTRIES);
  localparam int PW = AW + 1;
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);
  localparam int DW = 32 + 16 + PW;

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_WAIT = 4'd3,
    S_CHK = 4'd4, S_UNL = 4'd5, S_APP = 4'd6, S_DONE = 4'd7, S_ENQ = 4'd8, S_OUT = 4'd9;

  logic [3:0] state;
  req_t cur;
  logic [PW-1:0] qhead [QUEUES];
  logic [PW-1:0] qtail [QUEUES];
  logic [6:0]    qcnt  [QUEUES];
  logic [PW-1:0] free_head;
  logic [PW-1:0] walk, prev, nx, hit;
  logic [AW:0]   steps;
  logic [6:0]    removed;
  logic [31:0]   hit_id;
  logic [15:0]   hit_own;
  logic [AW:0]   init_cnt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [31:0]   rd_id;
  logic [15:0]   rd_own;
  logic [PW-1:0] rd_next;

  // write port is shared: link updates read-modify-write a whole slot word
  mqt_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  assign {rd_id, rd_own, rd_next} = rdata;

  logic [QW-1:0] q, dq, aq;
  logic q_ok, dq_ok;
  assign q  = cur.queue_sel[QW-1:0];
  assign dq = cur.dest_queue[QW-1:0];
  // append target: dest queue for move, own queue for enqueue
  assign aq = (cur.command == CMD_MOVE) ? dq : q;
  assign q_ok  = 32'(cur.queue_sel) < QUEUES;
  assign dq_ok = 32'(cur.dest_queue) < QUEUES;

  // sub-steps within a slot: phase counter for read-modify-write of links
  logic [1:0] ph;
  logic [DW-1:0] hold;

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_INIT;
      init_cnt <= '0;
      rsp_valid <= 1'b0;
      free_head <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        qhead[i] <= NIL; qtail[i] <= NIL; qcnt[i] <= '0;
      end
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      case (state)
        S_INIT: begin
          we <= 1'b1;
          waddr <= init_cnt[AW-1:0];
          wdata <= {48'd0, PW'(init_cnt) + PW'(1)};
          init_cnt <= init_cnt + 1'b1;
          if (32'(init_cnt) == ENTRIES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid && !req_stall) begin
            cur <= req;
            removed <= '0;
            hit <= NIL;
            prev <= NIL;
            steps <= '0;
            ph <= '0;
            state <= S_OUT;
            if (32'(req.queue_sel) < QUEUES) begin
              case (req.command)
                CMD_ENQ: begin
                  if (free_head != NIL) begin
                    raddr <= free_head[AW-1:0];
                    state <= S_ENQ;
                  end
                end
                CMD_REMID, CMD_FIND, CMD_REMFST, CMD_CLEAN: begin
                  walk <= qhead[req.queue_sel[QW-1:0]];
                  state <= S_RD;
                end
                CMD_MOVE: begin
                  if (32'(req.dest_queue) < QUEUES) begin
                    walk <= qhead[req.queue_sel[QW-1:0]];
                    state <= S_RD;
                  end
                end
                default: state <= S_OUT;
              endcase
            end
          end
        end
        S_ENQ: begin
          // raddr = free slot; wait then take its link
          if (ph == 2'd0) ph <= 2'd1;
          else if (ph == 2'd1) begin
            hit <= free_head;
            hit_id <= cur.msg_id;
            hit_own <= cur.owner_tag;
            free_head <= rd_next;
            hold <= {cur.msg_id, cur.owner_tag, NIL};
            ph <= 2'd0;
            state <= S_APP;
          end
        end
        S_RD: begin
          if (walk == NIL || 32'(steps) >= ENTRIES) state <= S_DONE;
          else begin
            raddr <= walk[AW-1:0];
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_CHK;
        S_CHK: begin
          nx <= rd_next;
          steps <= steps + 1'b1;
          if (cur.command == CMD_CLEAN) begin
            if (rd_own == cur.owner_tag) begin
              hit <= walk; hold <= rdata;
              removed <= removed + 1'b1;
              state <= S_UNL;
            end else begin
              prev <= walk; walk <= rd_next; state <= S_RD;
            end
          end else if (cur.command == CMD_REMFST || rd_id == cur.msg_id) begin
            hit <= walk; hit_id <= rd_id; hit_own <= rd_own; hold <= rdata;
            state <= (cur.command == CMD_FIND) ? S_DONE : S_UNL;
          end else begin
            prev <= walk; walk <= rd_next; state <= S_RD;
          end
        end
        S_UNL: begin
          // patch predecessor link, ph0 read prev, ph1 wait, ph2 write
          if (prev == NIL) begin
            qhead[q] <= nx;
            ph <= 2'd3;
          end else if (ph == 2'd0) begin
            raddr <= prev[AW-1:0]; ph <= 2'd1;
          end else if (ph == 2'd1) ph <= 2'd2;
          else if (ph == 2'd2) begin
            we <= 1'b1; waddr <= prev[AW-1:0];
            wdata <= {rdata[DW-1:PW], nx};
            ph <= 2'd3;
          end
          if (ph == 2'd3) begin
            ph <= 2'd0;
            if (qtail[q] == hit) qtail[q] <= prev;
            qcnt[q] <= qcnt[q] - 7'd1;
            if (cur.command == CMD_MOVE) state <= S_APP;
            else begin
              we <= 1'b1; waddr <= hit[AW-1:0];
              wdata <= {hold[DW-1:PW], free_head};
              free_head <= hit;
              if (cur.command == CMD_CLEAN) begin
                walk <= nx; state <= S_RD;
              end else state <= S_DONE;
            end
          end
        end
        S_APP: begin
          if (ph == 2'd0) begin
            we <= 1'b1; waddr <= hit[AW-1:0];
            wdata <= {hold[DW-1:PW], NIL};
            ph <= 2'd1;
          end else if (ph == 2'd1) begin
            raddr <= qtail[aq][AW-1:0]; ph <= 2'd2;
          end else if (ph == 2'd2) ph <= 2'd3;
          else begin
            ph <= 2'd0;
            if (qtail[aq] != NIL) begin
              we <= 1'b1; waddr <= qtail[aq][AW-1:0];
              wdata <= {rdata[DW-1:PW], hit};
            end else qhead[aq] <= hit;
            qtail[aq] <= hit;
            qcnt[aq] <= qcnt[aq] + 7'd1;
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_OUT;
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp.removed_count <= (cur.command == CMD_CLEAN && q_ok) ? removed : '0;
            rsp.queue_length <= q_ok ? qcnt[q] : '0;
            rsp.slot_index <= '0; rsp.found_msg_id <= '0; rsp.found_owner <= '0;
            rsp.status <= ST_NOTFOUND;
            if (q_ok) begin
              case (cur.command)
                CMD_ENQ: rsp.status <= (hit == NIL) ? ST_FULL : ST_OK;
                CMD_REMFST: rsp.status <= (hit == NIL) ? ST_EMPTY : ST_OK;
                CMD_CLEAN: rsp.status <= ST_OK;
                CMD_REMID, CMD_FIND: rsp.status <= (hit == NIL) ? ST_NOTFOUND : ST_OK;
                CMD_MOVE: rsp.status <= (hit == NIL || !dq_ok) ? ST_NOTFOUND : ST_OK;
                default: rsp.status <= ST_NOTFOUND;
              endcase
              if (hit != NIL && cur.command != CMD_CLEAN) begin
                rsp.slot_index <= 6'(hit);
                rsp.found_msg_id <= hit_id;
                rsp.found_owner <= hit_own;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MQT_ASSERT_IMPL(a_stall_busy, clk, rst, state != S_IDLE, req_stall)
  `MQT_ASSERT_NEXT(a_one_rsp, clk, rst, rsp_valid && rsp_stall, rsp_valid)
  `MQT_ASSERT_IMPL(a_free_rng, clk, rst, state == S_IDLE, free_head <= NIL)
endmodule
